FILE: sv/blq_pkg.sv
// Package for the battery level qualifier: register map, config bundle,
// sequencer states, verdict codes and arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package blq_pkg;

  localparam int unsigned BLQ_SAMPLE_BITS = 10;
  localparam int unsigned BLQ_LEVEL_COUNT = 3;

  localparam int unsigned INPUT_W  = 10;
  localparam int unsigned VOLT_W   = 16;
  localparam int unsigned LEVEL_W  = 2;
  localparam int unsigned VERD_W   = 2;
  localparam int unsigned LIMIT_W  = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned THR_REGS = 3;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned VREF_SCALE   = 124;
  localparam int unsigned RAW_FACTOR   = 'h181;
  localparam int unsigned SCALE_FACTOR = 3 * VREF_SCALE;
  localparam int unsigned ROUND_OFFSET = 2 * RAW_FACTOR;

  localparam logic [VOLT_W-1:0]  THR_ONE_RST    = 16'h0156;
  localparam logic [VOLT_W-1:0]  THR_TWO_RST    = 16'h015b;
  localparam logic [VOLT_W-1:0]  THR_THREE_RST  = 16'h015f;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 8'd5;
  localparam logic [LIMIT_W-1:0] GOOD_LIMIT_RST = 8'd20;

  typedef enum logic [2:0] {
    REG_RATIO_MODE,
    REG_THR_ONE,
    REG_THR_TWO,
    REG_THR_THREE,
    REG_LOW_LIMIT,
    REG_GOOD_LIMIT
  } reg_idx_e;

  typedef enum logic [VERD_W-1:0] {
    VERDICT_NONE,
    VERDICT_LOW,
    VERDICT_ENOUGH
  } verdict_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } blq_state_e;

  typedef struct packed {
    logic                             ratio_mode;
    logic [THR_REGS-1:0][VOLT_W-1:0]  thr;
    logic [LIMIT_W-1:0]               low_limit;
    logic [LIMIT_W-1:0]               good_limit;
  } blq_cfg_t;

endpackage
`default_nettype wire

FILE: sv/battery_level_qualifier_core.sv
// Battery level qualifier: ADC sample pair in, ratio voltage, level and
// verdict out. Depends on blq_pkg, blq_regs, blq_divider, blq_qualifier.
//
// Input stream: s_axis_tdata carries input_sample (bits 9:0) and ref_sample
// (bits 19:10). Output stream: m_axis_tdata carries voltage_value (15:0),
// charge_level (17:16) and verdict (19:18). Configuration through the APB
// port: six registers at byte addresses 0, 4, ... 20.
// Each accepted transfer has its numerator formed, then passes through the
// bit-serial divider for an NUM_W-bit quotient (20 bits for 10-bit samples),
// then is graded and qualified. A new transfer is not taken until the
// previous one has left the final step.
// s_axis_tready is high only while the sequencer idles. The result sits in
// an output register, so the next transfer is accepted while it waits; if
// the receiver still stalls when the next result is ready, the sequencer
// holds in its final step until the register frees.
// Reset restores the register defaults, clears both counters and drops
// m_axis_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module battery_level_qualifier_core #(
  parameter int unsigned SAMPLE_BITS = blq_pkg::BLQ_SAMPLE_BITS,
  parameter int unsigned LEVEL_COUNT = blq_pkg::BLQ_LEVEL_COUNT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [9:0] input_sample, [19:10] ref_sample, [23:20] zero
  input  wire logic [23:0]                s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [15:0] voltage_value, [17:16] charge_level, [19:18] verdict, [23:20] zero
  output logic      [23:0]                m_axis_tdata,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [blq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [blq_pkg::DATA_W-1:0] pwdata,
  output logic      [blq_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import blq_pkg::*;

  localparam int unsigned SMP_W = (SAMPLE_BITS < INPUT_W) ? SAMPLE_BITS : INPUT_W;
  localparam int unsigned NUM_W = SMP_W + 10;

  blq_cfg_t          cfg;
  blq_state_e        state_q, state_d;
  logic              in_fire;
  logic              emit_go;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  quotient;
  logic [NUM_W-1:0]  numerator;
  logic [SMP_W-1:0]  in_smp_q;
  logic [SMP_W-1:0]  ref_smp_q;
  logic [VOLT_W-1:0] voltage;
  logic [LEVEL_W-1:0] level;
  verdict_e          verdict;
  logic              out_valid_q, out_valid_d;
  logic [VOLT_W-1:0] out_vol_q;
  logic [LEVEL_W-1:0] out_lvl_q;
  verdict_e          out_verd_q;

  blq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_smp_q  <= s_axis_tdata[SMP_W-1:0];
      ref_smp_q <= s_axis_tdata[INPUT_W +: SMP_W];
    end
  end

  always_comb begin
    if (cfg.ratio_mode) begin
      numerator = NUM_W'(in_smp_q) * NUM_W'(RAW_FACTOR);
    end else begin
      numerator = NUM_W'(in_smp_q) * NUM_W'(SCALE_FACTOR) + NUM_W'(ROUND_OFFSET);
    end
  end

  blq_divider #(
    .NUM_W (NUM_W),
    .DEN_W (SMP_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numerator),
    .divisor_i  (ref_smp_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign voltage = (ref_smp_q == '0) ? {VOLT_W{1'b1}} : quotient[VOLT_W-1:0];

  blq_qualifier #(
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_qual (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .update_i  (emit_go),
    .voltage_i (voltage),
    .level_o   (level),
    .verdict_o (verdict)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_EMIT;
      ST_EMIT: if (emit_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    emit_go       = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL:  div_start     = 1'b1;
      ST_DIV:  ;
      ST_EMIT: emit_go       = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_vol_q  <= voltage;
      out_lvl_q  <= level;
      out_verd_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_verd_q, out_lvl_q, out_vol_q};

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_MUL)
    else $error("accepted transfer did not start the sequence");

  a_low_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_verd_q == VERDICT_LOW) |-> out_lvl_q <= LEVEL_W'(1))
    else $error("low verdict with a high level");

endmodule
`default_nettype wire

FILE: sv/blq_regs.sv
// Configuration register file with an APB-style slave port.
// Depends on blq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blq_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [blq_pkg::ADDR_W-1:0] paddr,
  input  wire logic [blq_pkg::DATA_W-1:0] pwdata,
  output logic      [blq_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output blq_pkg::blq_cfg_t               cfg_o
);
  import blq_pkg::*;

  blq_cfg_t   cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_RATIO_MODE: cfg_d.ratio_mode = pwdata[0];
        REG_THR_ONE:    cfg_d.thr[0]     = pwdata[VOLT_W-1:0];
        REG_THR_TWO:    cfg_d.thr[1]     = pwdata[VOLT_W-1:0];
        REG_THR_THREE:  cfg_d.thr[2]     = pwdata[VOLT_W-1:0];
        REG_LOW_LIMIT:  cfg_d.low_limit  = pwdata[LIMIT_W-1:0];
        REG_GOOD_LIMIT: cfg_d.good_limit = pwdata[LIMIT_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RATIO_MODE: prdata = DATA_W'(cfg_q.ratio_mode);
      REG_THR_ONE:    prdata = DATA_W'(cfg_q.thr[0]);
      REG_THR_TWO:    prdata = DATA_W'(cfg_q.thr[1]);
      REG_THR_THREE:  prdata = DATA_W'(cfg_q.thr[2]);
      REG_LOW_LIMIT:  prdata = DATA_W'(cfg_q.low_limit);
      REG_GOOD_LIMIT: prdata = DATA_W'(cfg_q.good_limit);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ratio_mode <= 1'b0;
      cfg_q.thr[0]     <= THR_ONE_RST;
      cfg_q.thr[1]     <= THR_TWO_RST;
      cfg_q.thr[2]     <= THR_THREE_RST;
      cfg_q.low_limit  <= LOW_LIMIT_RST;
      cfg_q.good_limit <= GOOD_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/blq_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on blq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blq_divider #(
  parameter int unsigned NUM_W = 20,
  parameter int unsigned DEN_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quotient_o
);
  import blq_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  assign trial      = {rem_q, quo_q[NUM_W-1]};
  assign diff       = trial - {1'b0, den_q};
  assign fits       = trial >= {1'b0, den_q};
  assign done_o     = busy_q && (step_q == LAST_STEP);
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      den_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d  = {quo_q[NUM_W-2:0], fits};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

endmodule
`default_nettype wire

FILE: sv/blq_qualifier.sv
// Grades the voltage against the thresholds and runs the low and good
// counters that qualify the level into a verdict. Depends on blq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module blq_qualifier #(
  parameter int unsigned LEVEL_COUNT = blq_pkg::BLQ_LEVEL_COUNT
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire blq_pkg::blq_cfg_t           cfg_i,
  input  wire logic                        update_i,
  input  wire logic [blq_pkg::VOLT_W-1:0]  voltage_i,
  output logic      [blq_pkg::LEVEL_W-1:0] level_o,
  output blq_pkg::verdict_e                verdict_o
);
  import blq_pkg::*;

  localparam int unsigned LEVEL_USED = (LEVEL_COUNT > THR_REGS) ? THR_REGS : LEVEL_COUNT;

  logic [CNT_W-1:0] low_cnt_q, low_cnt_d;
  logic [CNT_W-1:0] good_cnt_q, good_cnt_d;
  logic             is_low;

  always_comb begin
    level_o = '0;
    for (int i = 0; i < LEVEL_USED; i++) begin
      if (voltage_i >= cfg_i.thr[i]) begin
        level_o = LEVEL_W'(i + 1);
      end
    end
  end

  assign is_low = level_o <= LEVEL_W'(1);

  always_comb begin
    low_cnt_d  = low_cnt_q;
    good_cnt_d = good_cnt_q;
    verdict_o  = VERDICT_NONE;
    if (is_low) begin
      if (good_cnt_q != '0) begin
        good_cnt_d = good_cnt_q - 1'b1;
      end
      if (low_cnt_q > CNT_W'(cfg_i.low_limit)) begin
        low_cnt_d = '0;
        verdict_o = VERDICT_LOW;
      end else begin
        low_cnt_d = low_cnt_q + 1'b1;
      end
    end else begin
      if (good_cnt_q > CNT_W'(cfg_i.good_limit)) begin
        good_cnt_d = '0;
        verdict_o  = VERDICT_ENOUGH;
      end else begin
        good_cnt_d = good_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cnt_q  <= '0;
      good_cnt_q <= '0;
    end else if (update_i) begin
      low_cnt_q  <= low_cnt_d;
      good_cnt_q <= good_cnt_d;
    end
  end

endmodule
`default_nettype wire
